// File: hdl/sdb_pkg.sv
// Shared widths, register indexes and reset values for the sigma-delta
// background estimator. No dependencies.
`default_nettype none

package sdb_pkg;

    localparam int IDX_W   = 19;
    localparam int LUMA_W  = 8;
    localparam int AMP_W   = 4;
    localparam int CFG_W   = 8;
    localparam int TGT_W   = AMP_W + LUMA_W;
    localparam int RANGE_W = 25;   // holds any frame size up to 2**24

    typedef enum logic [1:0] {
        CFG_AMP   = 2'd0,
        CFG_FLOOR = 2'd1,
        CFG_CEIL  = 2'd2
    } t_cfg_idx;

    localparam logic [AMP_W-1:0]  AMP_RESET   = 4'd4;
    localparam logic [LUMA_W-1:0] FLOOR_RESET = 8'd2;
    localparam logic [LUMA_W-1:0] CEIL_RESET  = 8'd255;
    localparam logic [LUMA_W-1:0] VAR_INIT    = 8'd1;
    localparam logic [LUMA_W-1:0] LEVEL_MAX   = 8'd255;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_INIT   = 1'b1;

endpackage

`default_nettype wire

// File: hdl/sdb_in_if.sv
// Pixel request channel: valid/ready handshake plus one pixel.
// Depends on sdb_pkg for field widths.
`default_nettype none

interface sdb_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [sdb_pkg::IDX_W-1:0]     pixel_index;
    logic [sdb_pkg::LUMA_W-1:0]    luma;

    modport source (output valid, output kind, output pixel_index, output luma,
                    input ready);
    modport sink   (input valid, input kind, input pixel_index, input luma,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/sdb_out_if.sv
// Result channel: valid/ready handshake plus the per-pixel detection result.
// Depends on sdb_pkg for field widths.
`default_nettype none

interface sdb_out_if;
    logic                          valid;
    logic                          ready;
    logic                          foreground;
    logic [sdb_pkg::LUMA_W-1:0]    difference;
    logic [sdb_pkg::LUMA_W-1:0]    background_level;
    logic [sdb_pkg::LUMA_W-1:0]    variance_level;

    modport source (output valid, output foreground, output difference,
                    output background_level, output variance_level, input ready);
    modport sink   (input valid, input foreground, input difference,
                    input background_level, input variance_level, output ready);
endinterface

`default_nettype wire

// File: hdl/sigma_delta_background.sv
// Sigma-delta background estimator and motion detector, top level.
// Depends on sdb_pkg, sdb_in_if and sdb_out_if.
//
// - i_pix carries one request per pixel: kind (update or initialize),
//   pixel_index and luma; o_res returns one result per request, in order:
//   foreground flag, difference, new background and new variance.
// - Registers (amplification factor, variance floor, variance ceiling) are
//   written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write
//   them only while idle, as the block itself does not enforce it.
// - Acceptance registers the request together with the state memory read;
//   stage 1 advancing registers the updated state and the result.
// - Throughput: one request per cycle unless the receiver stalls. A request
//   for the pixel written in the previous cycle takes the fresh state from a
//   bypass register. Receiver stall: the result register holds, the stage
//   behind it holds one more request, and i_pix.ready drops once both are full.
// - Reset empties the pipeline and restores the register defaults; the state
//   memory is not cleared, so each pixel is initialized before its update.
// - A pixel_index at or beyond FRAME_PIXELS changes no state and returns an
//   all-zero result.
`default_nettype none

module sigma_delta_background #(
    parameter int FRAME_PIXELS = 524288
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [1:0]                    i_cfg_idx,
    input  wire [sdb_pkg::CFG_W-1:0]     i_cfg_data,
    sdb_in_if.sink                       i_pix,
    sdb_out_if.source                    o_res
);

    // The index field is 19 bits wide, so no more than 2**19 entries can be
    // addressed even if the frame is declared larger.
    localparam int MEM_DEPTH = (FRAME_PIXELS > (2 ** sdb_pkg::IDX_W)) ?
                               (2 ** sdb_pkg::IDX_W) : FRAME_PIXELS;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int LW        = sdb_pkg::LUMA_W;

    // ---------------- configuration registers ----------------
    logic [sdb_pkg::AMP_W-1:0] r_amp;
    logic [LW-1:0]             r_floor;
    logic [LW-1:0]             r_ceil;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp   <= sdb_pkg::AMP_RESET;
            r_floor <= sdb_pkg::FLOOR_RESET;
            r_ceil  <= sdb_pkg::CEIL_RESET;
        end else if (i_cfg_we) begin
            unique case (sdb_pkg::t_cfg_idx'(i_cfg_idx))
                sdb_pkg::CFG_AMP:   r_amp   <= i_cfg_data[sdb_pkg::AMP_W-1:0];
                sdb_pkg::CFG_FLOOR: r_floor <= i_cfg_data[LW-1:0];
                sdb_pkg::CFG_CEIL:  r_ceil  <= i_cfg_data[LW-1:0];
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    // ---------------- handshake control ----------------
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_adv;
    logic in_acc;

    assign s1_adv      = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign in_acc      = i_pix.valid && i_pix.ready;

    // Range check on the incoming index.
    logic in_range;
    assign in_range = sdb_pkg::RANGE_W'(i_pix.pixel_index) <
                      sdb_pkg::RANGE_W'(FRAME_PIXELS);

    // ---------------- stage 1: request + memory read ----------------
    logic              r_s1_kind;
    logic              r_s1_inrange;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [LW-1:0]     r_s1_luma;
    logic [LW-1:0]     r_rd_bg;
    logic [LW-1:0]     r_rd_var;

    // Per-pixel state: background in the upper byte, variance in the lower.
    logic [2*LW-1:0]   r_mem [MEM_DEPTH];

    // Bypass of the most recent write.
    logic              r_wb_valid;
    logic [ADDR_W-1:0] r_wb_addr;
    logic [LW-1:0]     r_wb_bg;
    logic [LW-1:0]     r_wb_var;

    logic [LW-1:0]     n_bg;
    logic [LW-1:0]     n_var;
    logic [LW-1:0]     n_diff;
    logic              n_fg;
    logic              wr_en;

    assign wr_en = s1_adv && r_s1_inrange;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_kind    <= i_pix.kind;
            r_s1_inrange <= in_range;
            r_s1_addr    <= i_pix.pixel_index[ADDR_W-1:0];
            r_s1_luma    <= i_pix.luma;
        end
        if (in_acc && in_range) begin
            {r_rd_bg, r_rd_var} <= r_mem[i_pix.pixel_index[ADDR_W-1:0]];
        end
        if (wr_en) begin
            r_mem[r_s1_addr] <= {n_bg, n_var};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wb_addr <= r_s1_addr;
            r_wb_bg   <= n_bg;
            r_wb_var  <= n_var;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_wb_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (wr_en) begin
                r_wb_valid <= 1'b1;
            end
        end
    end

    // ---------------- update arithmetic ----------------
    logic [LW-1:0]              cur_bg;
    logic [LW-1:0]              cur_var;
    logic [LW-1:0]              step_bg;
    logic [LW-1:0]              step_var;
    logic [LW-1:0]              clamp_var;
    logic [LW-1:0]              abs_diff;
    logic [sdb_pkg::TGT_W-1:0]  target;
    logic [sdb_pkg::TGT_W-1:0]  var_ext;

    always_comb begin
        // The state written last cycle is not yet visible at the read port.
        if (r_wb_valid && (r_wb_addr == r_s1_addr)) begin
            cur_bg  = r_wb_bg;
            cur_var = r_wb_var;
        end else begin
            cur_bg  = r_rd_bg;
            cur_var = r_rd_var;
        end

        // Background steps one toward the pixel.
        if (cur_bg < r_s1_luma) begin
            step_bg = cur_bg + LW'(1);
        end else if (cur_bg > r_s1_luma) begin
            step_bg = cur_bg - LW'(1);
        end else begin
            step_bg = cur_bg;
        end

        abs_diff = (step_bg > r_s1_luma) ? (step_bg - r_s1_luma)
                                         : (r_s1_luma - step_bg);

        target  = sdb_pkg::TGT_W'(r_amp) * sdb_pkg::TGT_W'(abs_diff);
        var_ext = sdb_pkg::TGT_W'(cur_var);

        // Variance steps one toward the target, saturating at full scale.
        if (var_ext < target) begin
            step_var = (cur_var == sdb_pkg::LEVEL_MAX) ? cur_var : cur_var + LW'(1);
        end else if (var_ext > target) begin
            step_var = cur_var - LW'(1);
        end else begin
            step_var = cur_var;
        end

        // Ceiling first, then floor: the floor wins when they cross.
        clamp_var = (step_var > r_ceil) ? r_ceil : step_var;
        if (clamp_var < r_floor) begin
            clamp_var = r_floor;
        end

        if (!r_s1_inrange) begin
            n_bg   = '0;
            n_var  = '0;
            n_diff = '0;
            n_fg   = 1'b0;
        end else if (r_s1_kind == sdb_pkg::KIND_INIT) begin
            n_bg   = r_s1_luma;
            n_var  = sdb_pkg::VAR_INIT;
            n_diff = '0;
            n_fg   = 1'b0;
        end else begin
            n_bg   = step_bg;
            // A zero difference leaves the variance as stored, unclamped.
            n_var  = (abs_diff != '0) ? clamp_var : cur_var;
            n_diff = abs_diff;
            n_fg   = (abs_diff >= n_var);
        end
    end

    // ---------------- result register ----------------
    logic          r_fg;
    logic [LW-1:0] r_diff;
    logic [LW-1:0] r_bg_out;
    logic [LW-1:0] r_var_out;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_fg      <= n_fg;
            r_diff    <= n_diff;
            r_bg_out  <= n_bg;
            r_var_out <= n_var;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.foreground       = r_fg;
    assign o_res.difference       = r_diff;
    assign o_res.background_level = r_bg_out;
    assign o_res.variance_level   = r_var_out;

endmodule

`default_nettype wire
